/* hdl/ebpt_pkg.sv */
package ebpt_pkg;

    localparam int TDATA_IN_W  = 24;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 16;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int ACC_W       = 11;
    localparam int SEL_W       = 3;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // command codes as seen on the input stream
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // byte register indexes
    localparam logic [2:0] REG_CTRL_A = 3'd0;
    localparam logic [2:0] REG_CTRL_B = 3'd1;
    localparam logic [2:0] REG_COUNT  = 3'd2;
    localparam logic [2:0] REG_CMP_A  = 3'd3;
    localparam logic [2:0] REG_CMP_B  = 3'd4;
    localparam logic [2:0] REG_MASK   = 3'd5;
    localparam logic [2:0] REG_FLAGS  = 3'd6;

    // waveform modes
    localparam logic [2:0] MODE_NORMAL   = 3'd0;
    localparam logic [2:0] MODE_PC       = 3'd1;
    localparam logic [2:0] MODE_CTC      = 3'd2;
    localparam logic [2:0] MODE_FAST     = 3'd3;
    localparam logic [2:0] MODE_PC_CMP   = 3'd5;
    localparam logic [2:0] MODE_FAST_CMP = 3'd7;

    // configuration register indexes
    localparam logic CFG_OVF_BIT  = 1'b0;
    localparam logic CFG_CMPA_BIT = 1'b1;

    localparam logic [SEL_W-1:0] OVF_BIT_RESET  = 3'd0;
    localparam logic [SEL_W-1:0] CMPA_BIT_RESET = 3'd1;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK  = CMD_TICK,
        OP_WRITE = CMD_WRITE,
        OP_READ  = CMD_READ,
        OP_NOP   = CMD_NONE
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [2:0] reg_idx;
        logic [7:0] data;
        logic [7:0] elapsed;
    } op_t;

    typedef struct packed {
        logic [SEL_W-1:0] ovf_bit;
        logic [SEL_W-1:0] cmpa_bit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       ovf_irq;
        logic       cmpa_irq;
    } result_t;

    // prescaler divisor, zero when the clock is stopped
    function automatic logic [ACC_W-1:0] clock_divisor(input logic [2:0] cs);
        logic [ACC_W-1:0] div;
        unique case (cs)
            3'd1:    div = 11'd1;
            3'd2:    div = 11'd8;
            3'd3:    div = 11'd64;
            3'd4:    div = 11'd256;
            3'd5:    div = 11'd1024;
            default: div = 11'd0;
        endcase
        return div;
    endfunction

endpackage

/* hdl/ebpt_front.sv */
module ebpt_front
    import ebpt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_IN_W-1:0] s_tdata,
    input  logic [TUSER_IN_W-1:0] s_tuser,
    output logic                  q_valid,
    output op_t                   q_item,
    input  logic                  q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    op_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             push;
    logic             pop;
    op_t              item_in;

    // classify the incoming word
    always_comb begin
        unique case (s_tuser[1:0])
            CMD_TICK:  item_in.kind = OP_TICK;
            CMD_WRITE: item_in.kind = OP_WRITE;
            CMD_READ:  item_in.kind = OP_READ;
            default:   item_in.kind = OP_NOP;
        endcase
        item_in.reg_idx = s_tdata[2:0];
        item_in.data    = s_tdata[10:3];
        item_in.elapsed = s_tdata[18:11];
    end

    assign s_tready = (fill_reg != FULL_CNT);
    assign q_valid  = (fill_reg != '0);
    assign q_item   = mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

/* hdl/ebpt_back.sv */
module ebpt_back
    import ebpt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   q_valid,
    input  op_t                    q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,
    output logic                   stepping
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_STEP = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    logic [7:0]       ctrl_a_reg, ctrl_a_next;
    logic [7:0]       ctrl_b_reg, ctrl_b_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       cmp_a_reg, cmp_a_next;
    logic [7:0]       cmp_b_reg, cmp_b_next;
    logic [7:0]       mask_reg, mask_next;
    logic [7:0]       flags_reg, flags_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             dir_up_reg, dir_up_next;
    logic             ovf_irq_reg, ovf_irq_next;
    logic             cmpa_irq_reg, cmpa_irq_next;
    logic             m_valid_reg, m_valid_next;
    result_t          m_data_reg, m_data_next;

    logic             out_free;
    logic             load_out;
    result_t          load_data;
    logic [ACC_W-1:0] div;
    logic [2:0]       mode;
    logic [7:0]       top;
    logic [7:0]       inc;
    logic [7:0]       dec;
    logic [8:0]       nxt9;
    logic [7:0]       step_count;
    logic             step_dir;
    logic [7:0]       step_flags;
    logic             step_ovf_irq;
    logic             step_cmpa_irq;
    logic [7:0]       read_val;

    assign out_free = !m_valid_reg || m_tready;
    assign div      = clock_divisor(ctrl_b_reg[2:0]);
    assign mode     = {ctrl_b_reg[3], ctrl_a_reg[1:0]};
    assign stepping = (state_reg == ST_STEP);

    // one prescaled counter step
    always_comb begin
        top = (mode == MODE_CTC || mode == MODE_PC_CMP || mode == MODE_FAST_CMP)
            ? cmp_a_reg : COUNT_MAX;
        inc        = count_reg + 8'd1;
        dec        = count_reg - 8'd1;
        nxt9       = {1'b0, count_reg} + 9'd1;
        step_count = count_reg;
        step_dir   = dir_up_reg;
        step_flags = flags_reg;
        if (mode == MODE_PC || mode == MODE_PC_CMP) begin
            if (dir_up_reg) begin
                if (inc >= top) begin
                    step_count = top;
                    step_dir   = 1'b0;
                end else begin
                    step_count = inc;
                end
            end else begin
                step_count = dec;
                if (dec == 8'd0) begin
                    step_dir      = 1'b1;
                    step_flags[0] = 1'b1;
                end
            end
        end else begin
            if (nxt9 > {1'b0, top}) begin
                step_count = 8'd0;
                if (mode == MODE_NORMAL || mode == MODE_FAST || mode == MODE_FAST_CMP) begin
                    step_flags[0] = 1'b1;
                end
                // ctc only flags the wrap from max
                if (mode == MODE_CTC && count_reg == COUNT_MAX) begin
                    step_flags[0] = 1'b1;
                end
            end else begin
                step_count = nxt9[7:0];
            end
        end
        if (step_count == cmp_a_reg && count_reg != cmp_a_reg) begin
            step_flags[1] = 1'b1;
        end
        if (step_count == cmp_b_reg && count_reg != cmp_b_reg) begin
            step_flags[2] = 1'b1;
        end
        step_ovf_irq  = step_flags[0] && mask_reg[cfg.ovf_bit];
        step_cmpa_irq = step_flags[1] && mask_reg[cfg.cmpa_bit];
        if (step_ovf_irq) begin
            step_flags[0] = 1'b0;
        end
        if (step_cmpa_irq) begin
            step_flags[1] = 1'b0;
        end
    end

    always_comb begin
        unique case (q_item.reg_idx)
            REG_CTRL_A: read_val = ctrl_a_reg;
            REG_CTRL_B: read_val = ctrl_b_reg;
            REG_COUNT:  read_val = count_reg;
            REG_CMP_A:  read_val = cmp_a_reg;
            REG_CMP_B:  read_val = cmp_b_reg;
            REG_MASK:   read_val = mask_reg;
            REG_FLAGS:  read_val = flags_reg;
            default:    read_val = 8'd0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        ctrl_a_next   = ctrl_a_reg;
        ctrl_b_next   = ctrl_b_reg;
        count_next    = count_reg;
        cmp_a_next    = cmp_a_reg;
        cmp_b_next    = cmp_b_reg;
        mask_next     = mask_reg;
        flags_next    = flags_reg;
        acc_next      = acc_reg;
        dir_up_next   = dir_up_reg;
        ovf_irq_next  = ovf_irq_reg;
        cmpa_irq_next = cmpa_irq_reg;
        q_pop         = 1'b0;
        load_out      = 1'b0;
        load_data     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    unique case (q_item.kind)
                        OP_TICK: begin
                            if (div != '0) begin
                                acc_next      = acc_reg + {3'b000, q_item.elapsed};
                                ovf_irq_next  = 1'b0;
                                cmpa_irq_next = 1'b0;
                                state_next    = ST_STEP;
                            end else begin
                                load_out = 1'b1;
                            end
                        end
                        OP_WRITE: begin
                            load_out = 1'b1;
                            unique case (q_item.reg_idx)
                                REG_CTRL_A: ctrl_a_next = q_item.data;
                                REG_CTRL_B: ctrl_b_next = q_item.data;
                                REG_COUNT:  count_next  = q_item.data;
                                REG_CMP_A:  cmp_a_next  = q_item.data;
                                REG_CMP_B:  cmp_b_next  = q_item.data;
                                REG_MASK:   mask_next   = q_item.data;
                                REG_FLAGS:  flags_next  = flags_reg & ~q_item.data;
                                default:    ;
                            endcase
                        end
                        OP_READ: begin
                            load_out            = 1'b1;
                            load_data.read_data = read_val;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_STEP: begin
                if (acc_reg >= div) begin
                    acc_next      = acc_reg - div;
                    count_next    = step_count;
                    dir_up_next   = step_dir;
                    flags_next    = step_flags;
                    ovf_irq_next  = ovf_irq_reg | step_ovf_irq;
                    cmpa_irq_next = cmpa_irq_reg | step_cmpa_irq;
                end else begin
                    // slot was free when the tick was taken and nothing else fills it
                    load_out           = 1'b1;
                    load_data.ovf_irq  = ovf_irq_reg;
                    load_data.cmpa_irq = cmpa_irq_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = load_data;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ctrl_a_reg  <= '0;
            ctrl_b_reg  <= '0;
            count_reg   <= '0;
            cmp_a_reg   <= '0;
            cmp_b_reg   <= '0;
            mask_reg    <= '0;
            flags_reg   <= '0;
            acc_reg     <= '0;
            dir_up_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ctrl_a_reg  <= ctrl_a_next;
            ctrl_b_reg  <= ctrl_b_next;
            count_reg   <= count_next;
            cmp_a_reg   <= cmp_a_next;
            cmp_b_reg   <= cmp_b_next;
            mask_reg    <= mask_next;
            flags_reg   <= flags_next;
            acc_reg     <= acc_next;
            dir_up_reg  <= dir_up_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ovf_irq_reg  <= ovf_irq_next;
        cmpa_irq_reg <= cmpa_irq_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg.cmpa_irq, m_data_reg.ovf_irq, m_data_reg.read_data};

endmodule

/* hdl/eight_bit_pwm_timer_core.sv */
// path: a word is registered in the input queue, then a read, a write or a tick with
//   the clock stopped loads the output register; a running tick first takes its
//   prescaled counter steps, one step per cycle, so ticks are bound by the step loop
// throughput: one word per cycle for register access while the output is not stalled
// reset: synchronous active-low aresetn clears the timer registers, count direction up,
//   interrupt enable positions at their defaults, queue empty, no result pending
module eight_bit_pwm_timer_core
    import ebpt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // register_index[2:0], write_data[10:3], elapsed_cycles[18:11], zero pad
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [TUSER_IN_W-1:0]  s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // read_data[7:0], overflow_irq[8], compare_a_irq[9], zero pad
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [SEL_W-1:0] ovf_bit_reg, ovf_bit_next;
    logic [SEL_W-1:0] cmpa_bit_reg, cmpa_bit_next;
    cfg_t             cfg;
    logic             cfg_wr;
    logic             q_valid;
    op_t              q_item;
    logic             q_pop;
    logic             stepping;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        ovf_bit_next  = ovf_bit_reg;
        cmpa_bit_next = cmpa_bit_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                CFG_OVF_BIT:  ovf_bit_next  = pwdata[SEL_W-1:0];
                CFG_CMPA_BIT: cmpa_bit_next = pwdata[SEL_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovf_bit_reg  <= OVF_BIT_RESET;
            cmpa_bit_reg <= CMPA_BIT_RESET;
        end else begin
            ovf_bit_reg  <= ovf_bit_next;
            cmpa_bit_reg <= cmpa_bit_next;
        end
    end

    assign prdata = (paddr[2] == CFG_CMPA_BIT)
        ? {{(APB_DATA_W-SEL_W){1'b0}}, cmpa_bit_reg}
        : {{(APB_DATA_W-SEL_W){1'b0}}, ovf_bit_reg};

    assign cfg.ovf_bit  = ovf_bit_reg;
    assign cfg.cmpa_bit = cmpa_bit_reg;

    ebpt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    ebpt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .stepping (stepping)
    );

    // a read result never carries an interrupt
    a_read_no_irq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tdata[7:0] != 8'd0) |-> (m_axis_tdata[9:8] == 2'b00))
        else $error("interrupt bits set on a read result");

    // the queue is not drained while a tick is still stepping
    a_no_pop_while_stepping: assert property (@(posedge aclk) disable iff (!aresetn)
        stepping |-> !q_pop)
        else $error("queue popped during step loop");

    // an accepted word is visible to the executor on the next cycle
    a_accept_reaches_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> q_valid)
        else $error("accepted word lost before the queue");

    // interrupt enable positions come out of reset at their defaults
    a_cfg_reset: assert property (@(posedge aclk)
        aresetn && $past(!aresetn)
        |-> (ovf_bit_reg == OVF_BIT_RESET) && (cmpa_bit_reg == CMPA_BIT_RESET))
        else $error("configuration not at reset value");

endmodule
